[rtl/assert_macros.svh]
// Assertion macros for the filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_AT(lbl, clk, rst_n, !(cond), msg)
`else
`define ASSERT_AT(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

[rtl/g5f_pkg.sv]
// Shared constants and types of the 5x5 binomial filter.
package g5f_pkg;
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_DIM    = 5;
  localparam int LINES      = 4;
  localparam int SLOT_W     = $clog2(LINES);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int EW_W       = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W      = 13;
  localparam int PIX_W      = 8;
  localparam int CFG_W      = 13;
  localparam int CFG_IDX_W  = 3;
  localparam int VS_W       = 12;
  localparam int HS_W       = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_MODE   = 3'd2,
    REG_VALUE  = 3'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    BORDER_UNDEF = 2'd0,
    BORDER_CONST = 2'd1,
    BORDER_REPL  = 2'd2
  } border_e;

  typedef logic [PIX_W-1:0] pix_t;

  // 1-4-6-4-1 binomial taps
  localparam int unsigned TAP [5] = '{1, 4, 6, 4, 1};
endpackage

[rtl/g5f_pix_if.sv]
// Input pixel channel of the filter.
interface g5f_pix_if import g5f_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;
  logic             flush;

  modport source (output valid, pixel_in, flush, input ready);
  modport sink   (input valid, pixel_in, flush, output ready);
endinterface

[rtl/g5f_res_if.sv]
// Result pixel channel of the filter.
interface g5f_res_if import g5f_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             in_valid;
  logic             frame_end;

  modport source (output valid, pixel_out, in_valid, frame_end, input ready);
  modport sink   (input valid, pixel_out, in_valid, frame_end, output ready);
endinterface

[rtl/g5f_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module g5f_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read returns the old word on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[rtl/gaussian_5x5_filter_u8_unit.sv]
// Top level of the streaming 5x5 binomial blur for 8-bit pixels.
// Pixels enter in raster order, one transfer per cycle while the input channel is
// ready. Each pixel writes one of four line memories (MAX_WIDTH deep each, one
// write and one read per cycle) and the read column shifts into a 5x5 window; the
// first result that an input causes passes in turn through stage 1, the window of
// stage 2, the column sums of stage 3 and the output register. From the third row
// of a frame on, an input at the last column of a row gives three results, and the
// single output register delivers one result per cycle while the receiver is
// ready, so that input holds stage 2 until all three results have left it.
// After the frame send 2*W filler transfers to drain the last two rows. The
// line memories need no clearing: a word of an earlier frame never reaches a
// result.
`include "assert_macros.svh"
module gaussian_5x5_filter_u8_unit
  import g5f_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  g5f_pix_if.sink              pix_i,
  g5f_res_if.source            res_o
);
  // configuration
  logic [11:0]      cfg_width_q;
  logic [ROW_W-1:0] cfg_height_q;
  logic [1:0]       cfg_mode_q;
  pix_t             cfg_value_q;
  logic [EW_W-1:0]  eff_w;
  logic [ROW_W-1:0] eff_h;
  logic             undef_mode, const_mode;

  // position counters
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic             last_col;
  logic             accept;
  pix_t             px_in;
  logic             size_wr;

  // stage 1: line memory read in flight
  logic             s1_valid_q;
  pix_t             s1_px_q;
  logic [ROW_W-1:0] s1_row_q;
  logic [COL_W-1:0] s1_col_q;
  logic             s1_last_q;
  pix_t             line_rd [LINES];

  // stage 2: window and result issue
  pix_t             win_q [5][5];
  logic [ROW_W-1:0] s2_row_q;
  logic [COL_W-1:0] s2_col_q;
  logic [1:0]       s2_left_q;
  logic [1:0]       s2_emit_q;
  logic [1:0]       s1_count;

  // stage 3: column sums
  logic             p_valid_q;
  logic [VS_W-1:0]  p_vsum_q [5];
  logic             p_zero_q;
  logic             p_end_q;

  // output register
  logic             out_valid_q;
  pix_t             out_pix_q;
  logic             out_inv_q;
  logic             out_end_q;

  // handshake control
  logic             out_free, p_free, emit, s2_free, s1_move;

  // datapath of stage 2
  logic [2:0]       rsrc [5];
  logic [2:0]       csrc [5];
  logic [4:0]       rout, cout;
  logic [VS_W-1:0]  vsum_d [5];
  logic             zero_d, end_d;
  logic [HS_W-1:0]  hsum;
  pix_t             pix_d;

  // clamp the frame size to the supported range
  always_comb begin
    if (32'(cfg_width_q) < 32'(MIN_DIM)) eff_w = EW_W'(MIN_DIM);
    else if (32'(cfg_width_q) > 32'(MAX_WIDTH)) eff_w = EW_W'(MAX_WIDTH);
    else eff_w = EW_W'(cfg_width_q);
    if (32'(cfg_height_q) < 32'(MIN_DIM)) eff_h = ROW_W'(MIN_DIM);
    else if (32'(cfg_height_q) > 32'(MAX_HEIGHT)) eff_h = ROW_W'(MAX_HEIGHT);
    else eff_h = cfg_height_q;
  end

  assign const_mode = (cfg_mode_q == BORDER_CONST);
  assign undef_mode = (cfg_mode_q != BORDER_CONST) && (cfg_mode_q != BORDER_REPL);

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= 12'd640;
      cfg_height_q <= ROW_W'(480);
      cfg_mode_q   <= BORDER_UNDEF;
      cfg_value_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WIDTH:  cfg_width_q  <= cfg_data_i[11:0];
        REG_HEIGHT: cfg_height_q <= cfg_data_i[ROW_W-1:0];
        REG_MODE:   cfg_mode_q   <= cfg_data_i[1:0];
        REG_VALUE:  cfg_value_q  <= cfg_data_i[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  assign size_wr = cfg_we_i && ((cfg_index_i == REG_WIDTH) || (cfg_index_i == REG_HEIGHT));

  // handshake: each stage moves when the one after it frees up
  assign out_free    = !out_valid_q || res_o.ready;
  assign p_free      = !p_valid_q || out_free;
  assign emit        = (s2_left_q != 2'd0) && p_free;
  assign s2_free     = (s2_left_q == 2'd0) || ((s2_left_q == 2'd1) && p_free);
  assign s1_move     = s1_valid_q && s2_free;
  assign pix_i.ready = !s1_valid_q || s2_free;
  assign accept      = pix_i.valid && pix_i.ready;

  assign last_col = (EW_W'(col_q) + EW_W'(1)) == eff_w;
  assign px_in    = (row_q < eff_h) ? pix_i.pixel_in : '0;

  // advance the raster position; size writes start a new frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (size_wr) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        if ((ROW_W + 1)'(row_q) + 1'b1 >= (ROW_W + 1)'(eff_h) + 2'd2) row_q <= '0;
        else row_q <= row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // line memories: write the new pixel, read the four rows above it
  for (genvar i = 0; i < LINES; i++) begin : g_line
    g5f_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clk_i   (clk_i),
      .we_i    (accept && (row_q[SLOT_W-1:0] == SLOT_W'(i))),
      .waddr_i (col_q),
      .wdata_i (px_in),
      .re_i    (accept),
      .raddr_i (col_q),
      .rdata_o (line_rd[i])
    );
  end

  // stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (pix_i.ready) begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_px_q   <= px_in;
      s1_row_q  <= row_q;
      s1_col_q  <= col_q;
      s1_last_q <= last_col;
    end
  end

  // results owed by the item: none in the first two rows and columns
  always_comb begin
    if ((s1_row_q >= ROW_W'(2)) && (s1_col_q >= COL_W'(2))) s1_count = s1_last_q ? 2'd3 : 2'd1;
    else s1_count = 2'd0;
  end

  // stage 2: shift the window and count off the results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_left_q <= 2'd0;
      s2_emit_q <= 2'd0;
      for (int k = 0; k < 5; k++) begin
        for (int j = 0; j < 5; j++) win_q[k][j] <= '0;
      end
    end else if (s1_move) begin
      s2_left_q <= s1_count;
      s2_emit_q <= 2'd0;
      for (int k = 0; k < 5; k++) begin
        for (int j = 0; j < 4; j++) win_q[k][j] <= win_q[k][j+1];
        if (k < LINES) win_q[k][4] <= line_rd[SLOT_W'(s1_row_q[SLOT_W-1:0] + SLOT_W'(k))];
        else win_q[k][4] <= s1_px_q;
      end
    end else if (emit) begin
      s2_left_q <= s2_left_q - 2'd1;
      s2_emit_q <= s2_emit_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      s2_row_q <= s1_row_q;
      s2_col_q <= s1_col_q;
    end
  end

  // map each tap onto a window entry, folding in the border rule
  always_comb begin
    logic signed [15:0] r, c, h, w, y, x, yy, xx, s;
    r = signed'(16'(s2_row_q));
    c = signed'(16'(s2_col_q));
    h = signed'(16'(eff_h));
    w = signed'(16'(eff_w));
    y = r - 16'sd2;
    x = c - 16'sd2 + signed'(16'(s2_emit_q));
    for (int k = 0; k < 5; k++) begin
      yy = r - 16'sd4 + 16'(k);
      if (yy < 0) begin
        rout[k] = 1'b1;
        rsrc[k] = 3'(16'sd4 - r);
      end else if (yy >= h) begin
        rout[k] = 1'b1;
        rsrc[k] = 3'(h + 16'sd3 - r);
      end else begin
        rout[k] = 1'b0;
        rsrc[k] = 3'(k);
      end
    end
    for (int j = 0; j < 5; j++) begin
      s  = 16'(j) + signed'(16'(s2_emit_q));
      xx = c - 16'sd4 + s;
      if (xx < 0) begin
        cout[j] = 1'b1;
        csrc[j] = 3'(16'sd4 - c);
      end else if (s > 16'sd4) begin
        cout[j] = 1'b1;
        csrc[j] = 3'd4;
      end else begin
        cout[j] = 1'b0;
        csrc[j] = 3'(s);
      end
    end
    zero_d = undef_mode && ((y < 16'sd2) || (y >= h - 16'sd2) ||
                            (x < 16'sd2) || (x >= w - 16'sd2));
    end_d  = (y == h - 16'sd1) && (x == w - 16'sd1);
  end

  // vertical 1-4-6-4-1 sums per window column
  always_comb begin
    pix_t elem;
    for (int j = 0; j < 5; j++) begin
      vsum_d[j] = '0;
      for (int k = 0; k < 5; k++) begin
        elem = (const_mode && (rout[k] || cout[j])) ? cfg_value_q : win_q[rsrc[k]][csrc[j]];
        vsum_d[j] = vsum_d[j] + VS_W'(TAP[k]) * VS_W'(elem);
      end
    end
  end

  // stage 3
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (p_free) begin
      p_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      p_vsum_q <= vsum_d;
      p_zero_q <= zero_d;
      p_end_q  <= end_d;
    end
  end

  // horizontal sum, divide by 256, clamp
  always_comb begin
    hsum = '0;
    for (int j = 0; j < 5; j++) hsum = hsum + HS_W'(TAP[j]) * HS_W'(p_vsum_q[j]);
    if ((hsum >> 8) > HS_W'(255)) pix_d = 8'hFF;
    else pix_d = hsum[PIX_W+7:8];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && p_valid_q) begin
      out_pix_q <= p_zero_q ? '0 : pix_d;
      out_inv_q <= !p_zero_q;
      out_end_q <= p_end_q;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.pixel_out = out_pix_q;
  assign res_o.in_valid  = out_inv_q;
  assign res_o.frame_end = out_end_q;

  `ASSERT_AT(a_col_bound, clk_i, rst_ni, EW_W'(col_q) < eff_w, "column past frame width")
  `ASSERT_AT(a_row_bound, clk_i, rst_ni, (ROW_W + 1)'(row_q) <= (ROW_W + 1)'(eff_h) + 1'b1,
             "row past drain rows")
  `ASSERT_AT(a_s2_take, clk_i, rst_ni, s1_move |-> (s2_left_q <= 2'd1),
             "window overwritten with results owed")
  `ASSERT_NEVER(a_undef_end, clk_i, rst_ni,
                res_o.valid && res_o.frame_end && res_o.in_valid && undef_mode,
                "frame end flagged valid in undefined border mode")
endmodule

[sim/gaussian_5x5_filter_u8_unit_test.sv]
// Self-checking testbench of the streaming 5x5 binomial blur unit.
`timescale 1ns / 100ps

module gaussian_5x5_filter_u8_unit_test
  import g5f_pkg::*;
();

  localparam int  CYCLE_LIMIT = 2000000;
  localparam int  DRAIN_WAIT  = 16;

  typedef struct packed {
    pix_t pixel;
    logic flush;
  } src_item_t;

  typedef struct packed {
    pix_t pixel;
    logic in_valid;
    logic frame_end;
  } blur_res_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  g5f_pix_if pix_if ();
  g5f_res_if res_if ();

  gaussian_5x5_filter_u8_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_i       (pix_if.sink),
    .res_o       (res_if.source)
  );

  src_item_t pending_pixels[$];
  blur_res_t expected_pixels[$];
  int        mismatches;
  int        cycles;
  bit        no_idle;

  // Predictor state
  bit [7:0]  line_mem [0:LINES*MAX_WIDTH-1];
  bit [7:0]  window [0:24];
  int        col_cnt, row_cnt;
  bit [11:0] width_reg;
  bit [12:0] height_reg;
  bit [1:0]  mode_reg;
  bit [7:0]  value_reg;

  // Clock: 20 ns period
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int eff_w();
    int w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // Neighbor pixel with the border rule applied
  function automatic int neighbor(int yy, int xx, int r, int c, int w, int h);
    int k, j;
    if (yy < 0 || yy >= h || xx < 0 || xx >= w) begin
      if (mode_reg == BORDER_CONST) return value_reg;
      if (yy < 0) yy = 0;
      if (yy >= h) yy = h - 1;
      if (xx < 0) xx = 0;
      if (xx >= w) xx = w - 1;
    end
    k = yy - (r - 4);
    j = xx - (c - 4);
    if (k < 0 || k > 4 || j < 0 || j > 4) return 0;
    return window[k*5 + j];
  endfunction

  function automatic blur_res_t blur_pixel(int y, int x, int r, int c, int w, int h);
    blur_res_t res;
    int        sum;
    bit        undef;
    undef = (mode_reg != BORDER_CONST && mode_reg != BORDER_REPL);
    sum = 0;
    res.in_valid = 1'b1;
    if (undef && (y < 2 || y >= h - 2 || x < 2 || x >= w - 2)) begin
      res.pixel    = '0;
      res.in_valid = 1'b0;
    end else begin
      for (int dy = -2; dy <= 2; dy++)
        for (int dx = -2; dx <= 2; dx++)
          sum += TAP[dy+2] * TAP[dx+2] * neighbor(y + dy, x + dx, r, c, w, h);
      sum = sum >> 8;
      res.pixel = (sum > 255) ? 8'd255 : sum[7:0];
    end
    res.frame_end = (y == h - 1 && x == w - 1);
    return res;
  endfunction

  // Advance the predictor by one accepted transfer
  function automatic void blur_step(src_item_t it);
    int       w, h, c, r;
    bit [7:0] px;
    w = eff_w();
    h = eff_h();
    c = col_cnt;
    r = row_cnt;
    if (c >= w) c = w - 1;
    px = (r < h) ? it.pixel : 8'd0;
    for (int k = 0; k < 5; k++)
      for (int j = 0; j < 4; j++)
        window[k*5 + j] = window[k*5 + j + 1];
    for (int k = 0; k < 4; k++)
      window[k*5 + 4] = line_mem[((r + k) & 3) * MAX_WIDTH + c];
    window[24] = px;
    line_mem[(r & 3) * MAX_WIDTH + c] = px;
    if (r >= 2 && c >= 2) expected_pixels.push_back(blur_pixel(r - 2, c - 2, r, c, w, h));
    if (r >= 2 && c == w - 1) begin
      expected_pixels.push_back(blur_pixel(r - 2, w - 2, r, c, w, h));
      expected_pixels.push_back(blur_pixel(r - 2, w - 1, r, c, w, h));
    end
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h + 2) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  // Driver: hold valid until the transfer, idle at random between items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_if.valid    <= 1'b0;
      pix_if.pixel_in <= '0;
      pix_if.flush    <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        blur_step(pending_pixels[0]);
        void'(pending_pixels.pop_front());
        if (pending_pixels.size() > 0 && (no_idle || $urandom_range(99) >= 32)) begin
          pix_if.pixel_in <= pending_pixels[0].pixel;
          pix_if.flush    <= pending_pixels[0].flush;
        end else begin
          pix_if.valid <= 1'b0;
        end
      end else if (!pix_if.valid && pending_pixels.size() > 0 &&
                   (no_idle || $urandom_range(99) >= 32)) begin
        pix_if.valid    <= 1'b1;
        pix_if.pixel_in <= pending_pixels[0].pixel;
        pix_if.flush    <= pending_pixels[0].flush;
      end
    end
  end

  // Monitor: stall at random, check each result transfer against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: pixel %0d in_valid %0b frame_end %0b",
                     res_if.pixel_out, res_if.in_valid, res_if.frame_end);
        end else begin
          if (res_if.pixel_out !== expected_pixels[0].pixel ||
              res_if.in_valid !== expected_pixels[0].in_valid ||
              res_if.frame_end !== expected_pixels[0].frame_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp pixel %0d in_valid %0b frame_end %0b, got %0d %0b %0b",
                       expected_pixels[0].pixel, expected_pixels[0].in_valid,
                       expected_pixels[0].frame_end, res_if.pixel_out,
                       res_if.in_valid, res_if.frame_end);
          end
          void'(expected_pixels.pop_front());
        end
      end
      res_if.ready <= no_idle || ($urandom_range(99) >= 32);
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pending_pixels.size() > 0 || expected_pixels.size() > 0 || pix_if.valid)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value[CFG_W-1:0];
    case (idx)
      REG_WIDTH: begin
        width_reg = value[11:0];
        col_cnt   = 0;
        row_cnt   = 0;
      end
      REG_HEIGHT: begin
        height_reg = value[12:0];
        col_cnt    = 0;
        row_cnt    = 0;
      end
      REG_MODE:  mode_reg  = value[1:0];
      REG_VALUE: value_reg = value[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic setup(int w, int h, int mode, int value);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, mode);
    write_reg(REG_VALUE, value);
  endtask

  // Queue one frame; kind 0 random, 1 all zero, 2 all 255, 3 checkerboard.
  // A limit below the frame size leaves a broken frame.
  task automatic queue_frame(int kind, int limit);
    src_item_t it;
    int        w, h, n;
    w = eff_w();
    h = eff_h();
    n = 0;
    for (int y = 0; y < h + 2; y++)
      for (int x = 0; x < w; x++) begin
        if (n == limit) return;
        if (y < h) begin
          case (kind)
            1: it.pixel = 8'd0;
            2: it.pixel = 8'd255;
            3: it.pixel = ((x + y) & 1) ? 8'd255 : 8'd0;
            default: it.pixel = 8'($urandom_range(255));
          endcase
          it.flush = ($urandom_range(9) == 0);
        end else begin
          it.pixel = 8'($urandom_range(255));
          it.flush = ($urandom_range(9) != 0);
        end
        pending_pixels.push_back(it);
        n++;
      end
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    mismatches  = 0;
    cycles      = 0;
    no_idle     = 1'b0;
    col_cnt     = 0;
    row_cnt     = 0;
    width_reg   = 12'd640;
    height_reg  = 13'd480;
    mode_reg    = BORDER_UNDEF;
    value_reg   = 8'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, undefined and constant borders, clamped small size
    setup(5, 5, BORDER_UNDEF, 0);
    queue_frame(2, -1);
    setup(0, 0, BORDER_CONST, 255);
    queue_frame(1, -1);

    // Replicate border with no idling on either side
    setup(5, 6, BORDER_REPL, 0);
    no_idle = 1'b1;
    queue_frame(3, -1);
    wait_idle();
    no_idle = 1'b0;

    // Mode change within a frame leaves the counters alone
    setup(6, 5, 3, 99);
    queue_frame(0, 17);
    wait_idle();
    write_reg(REG_MODE, BORDER_CONST);
    write_reg(REG_VALUE, 200);
    queue_frame(0, 25);

    // Broken frames at the widest and tallest settings; each size write restarts
    setup(4095, 5, BORDER_REPL, 1);
    queue_frame(0, 9);
    setup(5, 8191, BORDER_CONST, 128);
    queue_frame(0, 30);

    // Random small frame
    setup($urandom_range(7, 5), $urandom_range(6, 5), $urandom_range(3),
          $urandom_range(255));
    queue_frame(0, -1);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
